// ----- src/acr_pkg.sv -----
// Package for the advertising chunk reassembler: payload types, function
// codes, tag bytes and default sizes. No dependencies.
`timescale 1ns / 1ps
package acr_pkg;

    // Function codes carried with each request
    localparam logic [1:0] FUNC_REPORT = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_SET_ID = 2'd2;

    // Structure and frame tag bytes
    localparam logic [7:0] AD_TYPE_MFG = 8'hFF;
    localparam logic [7:0] TAG_I       = 8'h49;
    localparam logic [7:0] TAG_V       = 8'h56;
    localparam logic [7:0] TYPE_Q      = 8'h51;
    localparam logic [7:0] MFG_HDR_MIN = 8'd10;

    localparam logic [15:0] COMPANY_ID_RESET = 16'hFFFF;
    localparam logic [15:0] HANDLED_ID_RESET = 16'hFFFF;
    localparam logic [9:0]  LEN_SAT          = 10'd1023;

    // Default sizes
    localparam int CHUNK_BYTES_DEF = 180;
    localparam int MESSAGE_MAX_DEF = 512;
    localparam int MAX_CHUNKS_DEF  = 3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  data_byte;
        logic        first_of_report;
        logic [7:0]  report_len;
        logic [8:0]  read_addr;
        logic [15:0] handled_id;
    } t_req;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        message_done;
        logic [15:0] message_id;
        logic [9:0]  message_len;
    } t_rsp;

    typedef logic [15:0] t_cfg;

endpackage

// ----- src/acr_stream_if.sv -----
// Valid/ready channel carrying one payload of type T per request.
// Used for the request, result and configuration channels.
`timescale 1ns / 1ps
interface acr_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/adv_chunk_reassembler_core.sv -----
// Advertising chunk reassembler: walks report structures, reassembles
// chunked question messages into a byte buffer. Depends on acr_pkg and
// acr_stream_if.
//
// Usage:
//   i_req  carries one request per handshake: a report byte (FUNC_REPORT),
//          a buffer byte read (FUNC_READ) or a handled-id load (FUNC_SET_ID).
//   o_rsp  returns exactly one result per request, in order. message_done
//          flags the report byte that completed a message, with its id and
//          total length; read_byte answers a buffer read.
//   i_cfg  writes the expected company id; it is always ready. The user must
//          write it only while no request is in flight; the block does not enforce it.
// Timing: one request per cycle sustained while o_rsp is not stalled. A request
// goes through an input register, where the parser, state update and buffer
// access run, then into the result register.
// Buffer read data comes from the registered read port of the buffer RAM.
// Reset clears the parser, session and result valid; the buffer holds
// garbage until written. If o_rsp stalls, the input register still takes one
// more request, then i_req.ready drops until the result is taken.
`timescale 1ns / 1ps
module adv_chunk_reassembler_core #(
    parameter int CHUNK_BYTES = acr_pkg::CHUNK_BYTES_DEF,
    parameter int MESSAGE_MAX = acr_pkg::MESSAGE_MAX_DEF,
    parameter int MAX_CHUNKS  = acr_pkg::MAX_CHUNKS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    acr_stream_if.sink    i_req,
    acr_stream_if.source  o_rsp,
    acr_stream_if.sink    i_cfg
);

    localparam int AW    = $clog2(MESSAGE_MAX);
    localparam int RAW   = ((AW > 9) ? AW : 9) + 1;
    localparam int SUM_W = $clog2(MAX_CHUNKS * CHUNK_BYTES + 256 + MESSAGE_MAX + 1);

    // Parser phases
    localparam logic [2:0] PH_LEN  = 3'd0;
    localparam logic [2:0] PH_TYPE = 3'd1;
    localparam logic [2:0] PH_SKIP = 3'd2;
    localparam logic [2:0] PH_HDR  = 3'd3;
    localparam logic [2:0] PH_PAY  = 3'd4;
    localparam logic [2:0] PH_DEAD = 3'd5;

    // Manufacturer header byte positions
    localparam logic [3:0] HB_CO_LO = 4'd0;
    localparam logic [3:0] HB_CO_HI = 4'd1;
    localparam logic [3:0] HB_TAG_I = 4'd2;
    localparam logic [3:0] HB_TAG_V = 4'd3;
    localparam logic [3:0] HB_TYPE  = 4'd4;
    localparam logic [3:0] HB_ID_LO = 4'd5;
    localparam logic [3:0] HB_ID_HI = 4'd6;
    localparam logic [3:0] HB_COUNT = 4'd7;
    localparam logic [3:0] HB_INDEX = 4'd8;

    // Handshake / pipeline
    logic          r_s1_valid;
    acr_pkg::t_req r_s1;
    logic          r_out_valid;
    logic          en;
    logic          proc;
    logic          req_fire;

    // Parser and session state
    logic [15:0]            r_company, n_company;
    logic [7:0]             r_pos, n_pos;
    logic [2:0]             r_phase, n_phase;
    logic [7:0]             r_rem, n_rem;
    logic [3:0]             r_hdr_cnt, n_hdr_cnt;
    logic [15:0]            r_id, n_id;
    logic [7:0]             r_cnt, n_cnt;
    logic [7:0]             r_idx, n_idx;
    logic [7:0]             r_plen, n_plen;
    logic [7:0]             r_pay_cnt, n_pay_cnt;
    logic [SUM_W-1:0]       r_pay_addr, n_pay_addr;
    logic                   r_we, n_we;
    logic                   r_active, n_active;
    logic [15:0]            r_sid, n_sid;
    logic [MAX_CHUNKS-1:0]  r_chunks, n_chunks;
    logic [9:0]             r_bytes, n_bytes;
    logic [15:0]            r_last, n_last;

    // Result registers
    logic        r_done;
    logic [15:0] r_mid;
    logic [9:0]  r_mlen;
    logic        r_rd_en;
    logic [7:0]  r_rd_data;

    // Working signals
    logic [7:0]            b;
    logic [7:0]            pos;
    logic [2:0]            ph;
    logic [7:0]            rem_dec;
    logic [9:0]            len_end;
    logic                  hdr_ok;
    logic                  chk;
    logic                  done;
    logic                  new_sess;
    logic                  wr_ok;
    logic [MAX_CHUNKS-1:0] idx_sel;
    logic [MAX_CHUNKS-1:0] full_mask;
    logic [MAX_CHUNKS-1:0] base_chunks;
    logic [9:0]            base_bytes;
    logic [10:0]           bytes_sum;
    logic [SUM_W-1:0]      off;
    logic [8:0]            pay_next;
    logic                  mem_we;
    logic [RAW-1:0]        rd_wide;
    logic                  rd_in_range;

    logic [7:0] mem [MESSAGE_MAX];

    assign en        = !r_out_valid || o_rsp.ready;
    assign proc      = en && r_s1_valid;
    assign req_fire  = i_req.valid && i_req.ready;
    assign i_req.ready = en || !r_s1_valid;
    assign i_cfg.ready = 1'b1;

    assign b           = r_s1.data_byte;
    assign rd_wide     = RAW'(r_s1.read_addr);
    assign rd_in_range = rd_wide < RAW'(MESSAGE_MAX);

    always_comb begin
        n_company = r_company;
        if (i_cfg.valid) begin
            n_company = i_cfg.data;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_CHUNKS; i++) begin
            idx_sel[i]   = (r_idx == 8'(i));
            full_mask[i] = (8'(i) < r_cnt);
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_rem      = r_rem;
        n_hdr_cnt  = r_hdr_cnt;
        n_id       = r_id;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_plen     = r_plen;
        n_pay_cnt  = r_pay_cnt;
        n_pay_addr = r_pay_addr;
        n_we       = r_we;
        n_active   = r_active;
        n_sid      = r_sid;
        n_chunks   = r_chunks;
        n_bytes    = r_bytes;
        n_last     = r_last;
        pos         = r_s1.first_of_report ? 8'd0 : r_pos;
        ph          = r_s1.first_of_report ? PH_LEN : r_phase;
        rem_dec     = r_rem - 8'd1;
        len_end     = 10'(pos) + 10'd1;
        hdr_ok      = 1'b1;
        chk         = 1'b0;
        done        = 1'b0;
        new_sess    = !r_active || (r_sid != r_id);
        base_chunks = new_sess ? '0 : r_chunks;
        base_bytes  = new_sess ? 10'd0 : r_bytes;
        bytes_sum   = 11'(base_bytes) + 11'(b);
        off         = SUM_W'(r_idx) * SUM_W'(CHUNK_BYTES);
        wr_ok       = ((base_chunks & idx_sel) == '0)
                      && ((off + SUM_W'(b)) <= SUM_W'(MESSAGE_MAX));
        pay_next    = 9'(r_pay_cnt) + 9'd1;
        mem_we      = 1'b0;

        if (proc) begin
            unique case (r_s1.func)
                acr_pkg::FUNC_REPORT: begin
                    n_pos   = (pos == 8'hFF) ? pos : pos + 8'd1;
                    n_phase = ph;
                    if (ph != PH_DEAD && pos < r_s1.report_len) begin
                        unique case (ph)
                            PH_LEN: begin
                                if (len_end >= 10'(r_s1.report_len) || b == 8'd0
                                    || len_end + 10'(b) > 10'(r_s1.report_len)) begin
                                    n_phase = PH_DEAD;
                                end else begin
                                    n_rem   = b;
                                    n_phase = PH_TYPE;
                                end
                            end
                            PH_TYPE: begin
                                n_rem = rem_dec;
                                if (b == acr_pkg::AD_TYPE_MFG
                                    && rem_dec >= acr_pkg::MFG_HDR_MIN) begin
                                    n_phase   = PH_HDR;
                                    n_hdr_cnt = 4'd0;
                                end else begin
                                    n_phase = (rem_dec != 8'd0) ? PH_SKIP : PH_LEN;
                                end
                            end
                            PH_SKIP: begin
                                n_rem = rem_dec;
                                if (rem_dec == 8'd0) begin
                                    n_phase = PH_LEN;
                                end
                            end
                            PH_HDR: begin
                                n_rem     = rem_dec;
                                n_hdr_cnt = r_hdr_cnt + 4'd1;
                                unique case (r_hdr_cnt)
                                    HB_CO_LO: hdr_ok = (b == r_company[7:0]);
                                    HB_CO_HI: hdr_ok = (b == r_company[15:8]);
                                    HB_TAG_I: hdr_ok = (b == acr_pkg::TAG_I);
                                    HB_TAG_V: hdr_ok = (b == acr_pkg::TAG_V);
                                    HB_TYPE:  hdr_ok = (b == acr_pkg::TYPE_Q);
                                    HB_ID_LO: n_id[7:0]  = b;
                                    HB_ID_HI: n_id[15:8] = b;
                                    HB_COUNT: n_cnt = b;
                                    HB_INDEX: n_idx = b;
                                    default: begin
                                        // last header byte: payload length
                                        n_plen = b;
                                        if (b > rem_dec || r_id == r_last || r_cnt == 8'd0
                                            || r_cnt > 8'(MAX_CHUNKS) || r_idx >= r_cnt) begin
                                            hdr_ok = 1'b0;
                                        end else begin
                                            n_active   = 1'b1;
                                            n_sid      = r_id;
                                            n_we       = wr_ok;
                                            n_chunks   = wr_ok ? (base_chunks | idx_sel)
                                                               : base_chunks;
                                            n_bytes    = !wr_ok ? base_bytes
                                                       : (bytes_sum > 11'(acr_pkg::LEN_SAT))
                                                       ? acr_pkg::LEN_SAT : bytes_sum[9:0];
                                            n_pay_cnt  = 8'd0;
                                            n_pay_addr = off;
                                            if (b == 8'd0) begin
                                                chk     = 1'b1;
                                                n_phase = (rem_dec != 8'd0) ? PH_SKIP
                                                                            : PH_LEN;
                                            end else begin
                                                n_phase = PH_PAY;
                                            end
                                        end
                                    end
                                endcase
                                if (!hdr_ok) begin
                                    n_phase = (rem_dec != 8'd0) ? PH_SKIP : PH_LEN;
                                end
                            end
                            PH_PAY: begin
                                n_rem      = rem_dec;
                                mem_we     = r_we;
                                n_pay_addr = r_pay_addr + SUM_W'(1);
                                n_pay_cnt  = pay_next[7:0];
                                if (pay_next >= 9'(r_plen)) begin
                                    chk     = 1'b1;
                                    n_phase = (rem_dec != 8'd0) ? PH_SKIP : PH_LEN;
                                end
                            end
                            default: n_phase = PH_DEAD;
                        endcase
                    end
                end
                acr_pkg::FUNC_SET_ID: n_last = r_s1.handled_id;
                default: ;
            endcase
        end

        // completion test against the current frame's chunk count
        if (chk && n_chunks == full_mask) begin
            n_active = 1'b0;
            n_last   = r_id;
            done     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_s1 <= i_req.data;
        end
        if (mem_we) begin
            mem[r_pay_addr[AW-1:0]] <= b;
        end
        if (proc) begin
            r_rd_data <= mem[rd_wide[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
            r_mid       <= '0;
            r_mlen      <= '0;
            r_rd_en     <= 1'b0;
            r_company   <= acr_pkg::COMPANY_ID_RESET;
            r_pos       <= '0;
            r_phase     <= PH_LEN;
            r_rem       <= '0;
            r_hdr_cnt   <= '0;
            r_id        <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_plen      <= '0;
            r_pay_cnt   <= '0;
            r_pay_addr  <= '0;
            r_we        <= 1'b0;
            r_active    <= 1'b0;
            r_sid       <= '0;
            r_chunks    <= '0;
            r_bytes     <= '0;
            r_last      <= acr_pkg::HANDLED_ID_RESET;
        end else begin
            r_company <= n_company;
            if (req_fire) begin
                r_s1_valid <= 1'b1;
            end else if (en) begin
                r_s1_valid <= 1'b0;
            end
            if (en) begin
                r_out_valid <= r_s1_valid;
                r_done      <= done;
                r_mid       <= done ? r_id : 16'd0;
                r_mlen      <= done ? n_bytes : 10'd0;
                r_rd_en     <= proc && (r_s1.func == acr_pkg::FUNC_READ) && rd_in_range;
            end
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_rem      <= n_rem;
            r_hdr_cnt  <= n_hdr_cnt;
            r_id       <= n_id;
            r_cnt      <= n_cnt;
            r_idx      <= n_idx;
            r_plen     <= n_plen;
            r_pay_cnt  <= n_pay_cnt;
            r_pay_addr <= n_pay_addr;
            r_we       <= n_we;
            r_active   <= n_active;
            r_sid      <= n_sid;
            r_chunks   <= n_chunks;
            r_bytes    <= n_bytes;
            r_last     <= n_last;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.data.read_byte    = r_rd_en ? r_rd_data : 8'd0;
    assign o_rsp.data.message_done = r_done;
    assign o_rsp.data.message_id   = r_mid;
    assign o_rsp.data.message_len  = r_mlen;

endmodule

// ----- src/acr_checker.sv -----
// Port-level checks for adv_chunk_reassembler_core, attached by bind.
// Depends on acr_pkg.
`timescale 1ns / 1ps
module acr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_ready,
    input logic          i_rsp_valid,
    input logic          i_rsp_ready,
    input acr_pkg::t_rsp i_rsp_data
);

    // result channel is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled result changed");

    // with the result register empty the block always takes a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid |-> i_req_ready)
        else $error("request refused with empty result register");

    // completion fields are zero unless a message completed; no read data with it
    a_done_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_data.message_done ? (i_rsp_data.read_byte == 8'd0)
                         : (i_rsp_data.message_id == 16'd0
                            && i_rsp_data.message_len == 10'd0)))
        else $error("completion fields inconsistent");

endmodule

bind adv_chunk_reassembler_core acr_checker u_acr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

// ----- tb/acr_sb_pkg.sv -----
// Scoreboard for the advertising chunk reassembler testbench: a bit-level
// predictor of the parser, session and buffer plus the queue of expected results.
// Depends on acr_pkg.
`timescale 1ns / 1ps
package acr_sb_pkg;
    import acr_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef enum int {
        AWAIT_LEN,
        AWAIT_TYPE,
        SKIP_BODY,
        MFG_HEADER,
        PAYLOAD,
        DROPPED
    } parse_state_e;

    class reassembly_scoreboard;
        logic [15:0]  company;
        logic [15:0]  handled;
        logic [7:0]   mem [MESSAGE_MAX_DEF];
        bit           was_written [MESSAGE_MAX_DEF];
        int           written_addrs [$];

        bit           sess_active;
        logic [15:0]  sess_id;
        logic [2:0]   chunk_mask;
        int unsigned  collected;

        parse_state_e state;
        int unsigned  pos;
        int unsigned  remaining;
        int unsigned  hdr_n;
        int unsigned  pay_n;
        logic [15:0]  f_id;
        int unsigned  f_count;
        int unsigned  f_index;
        int unsigned  f_plen;
        bit           wr_en;

        t_rsp         cur;
        t_rsp         expected_q [$];
        int           n_requests;
        int           n_reads;
        int           n_done;
        int           n_errors;

        function new();
            company     = COMPANY_ID_RESET;
            handled     = HANDLED_ID_RESET;
            sess_active = 1'b0;
            sess_id     = '0;
            chunk_mask  = '0;
            collected   = 0;
            state       = AWAIT_LEN;
            pos         = 0;
            remaining   = 0;
            hdr_n       = 0;
            pay_n       = 0;
            f_id        = '0;
            f_count     = 0;
            f_index     = 0;
            f_plen      = 0;
            wr_en       = 1'b0;
            n_requests  = 0;
            n_reads     = 0;
            n_done      = 0;
            n_errors    = 0;
            foreach (was_written[i]) was_written[i] = 1'b0;
        endfunction

        function void set_company(t_cfg v);
            company = v;
        endfunction

        function void finish_part();
            state = (remaining != 0) ? SKIP_BODY : AWAIT_LEN;
        endfunction

        // completion uses the chunk count of the frame just parsed
        function void test_complete();
            int unsigned full;
            full = (1 << f_count) - 1;
            if (int'(chunk_mask) == full) begin
                sess_active      = 1'b0;
                handled          = f_id;
                cur.message_done = 1'b1;
                cur.message_id   = f_id;
                cur.message_len  = 10'(collected);
            end
        endfunction

        function void close_header();
            int unsigned off;
            if (f_plen > remaining || f_id == handled || f_count == 0 ||
                f_count > MAX_CHUNKS_DEF || f_index >= f_count) begin
                finish_part();
                return;
            end
            if (!sess_active || sess_id != f_id) begin
                sess_active = 1'b1;
                sess_id     = f_id;
                chunk_mask  = '0;
                collected   = 0;
            end
            off   = f_index * CHUNK_BYTES_DEF;
            wr_en = !chunk_mask[f_index] && (off + f_plen <= MESSAGE_MAX_DEF);
            if (wr_en) begin
                chunk_mask[f_index] = 1'b1;
                collected = collected + f_plen;
                if (collected > LEN_SAT) collected = LEN_SAT;
            end
            pay_n = 0;
            if (f_plen == 0) begin
                test_complete();
                finish_part();
            end else begin
                state = PAYLOAD;
            end
        endfunction

        function void take_byte(logic [7:0] b, logic first, logic [7:0] rlen);
            int unsigned p;
            int unsigned h;
            int unsigned a;
            bit ok;
            if (first) begin
                pos   = 0;
                state = AWAIT_LEN;
            end
            p = pos;
            if (pos < 255) pos++;
            if (state == DROPPED || p >= rlen) return;
            case (state)
                AWAIT_LEN: begin
                    if (p + 1 >= rlen || b == 0 || p + 1 + b > rlen) begin
                        state = DROPPED;
                    end else begin
                        remaining = b;
                        state     = AWAIT_TYPE;
                    end
                end
                AWAIT_TYPE: begin
                    remaining--;
                    if (b == AD_TYPE_MFG && remaining >= MFG_HDR_MIN) begin
                        state   = MFG_HEADER;
                        hdr_n   = 0;
                        f_id    = '0;
                        f_count = 0;
                        f_index = 0;
                        f_plen  = 0;
                    end else begin
                        finish_part();
                    end
                end
                SKIP_BODY: begin
                    remaining--;
                    if (remaining == 0) state = AWAIT_LEN;
                end
                MFG_HEADER: begin
                    h = hdr_n;
                    hdr_n++;
                    remaining--;
                    ok = 1'b1;
                    // header byte order: company lo/hi, 'I', 'V', 'Q', id lo/hi,
                    // count, index, payload length
                    case (h)
                        0: ok = (b == company[7:0]);
                        1: ok = (b == company[15:8]);
                        2: ok = (b == TAG_I);
                        3: ok = (b == TAG_V);
                        4: ok = (b == TYPE_Q);
                        5: f_id[7:0] = b;
                        6: f_id[15:8] = b;
                        7: f_count = b;
                        8: f_index = b;
                        default: begin
                            f_plen = b;
                            close_header();
                        end
                    endcase
                    if (!ok) finish_part();
                end
                PAYLOAD: begin
                    a = f_index * CHUNK_BYTES_DEF + pay_n;
                    remaining--;
                    if (wr_en && a < MESSAGE_MAX_DEF) begin
                        mem[a] = b;
                        if (!was_written[a]) begin
                            was_written[a] = 1'b1;
                            written_addrs.push_back(a);
                        end
                    end
                    pay_n++;
                    if (pay_n >= f_plen) begin
                        test_complete();
                        finish_part();
                    end
                end
                default: state = DROPPED;
            endcase
        endfunction

        function void note_request(t_req q);
            cur = '0;
            n_requests++;
            case (q.func)
                FUNC_REPORT: take_byte(q.data_byte, q.first_of_report, q.report_len);
                FUNC_READ: begin
                    n_reads++;
                    if (q.read_addr < MESSAGE_MAX_DEF) cur.read_byte = mem[q.read_addr];
                end
                FUNC_SET_ID: handled = q.handled_id;
                default: ;
            endcase
            expected_q.push_back(cur);
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= REPORT_LIMIT)
                    $display("ERROR: result with no request pending: read=%h done=%b id=%h len=%0d",
                             got.read_byte, got.message_done, got.message_id, got.message_len);
                return;
            end
            want = expected_q.pop_front();
            if (want.message_done) n_done++;
            if (got.read_byte !== want.read_byte || got.message_done !== want.message_done ||
                got.message_id !== want.message_id || got.message_len !== want.message_len) begin
                n_errors++;
                if (n_errors <= REPORT_LIMIT)
                    $display("ERROR: mismatch exp read=%h done=%b id=%h len=%0d, got read=%h done=%b id=%h len=%0d",
                             want.read_byte, want.message_done, want.message_id, want.message_len,
                             got.read_byte, got.message_done, got.message_id, got.message_len);
            end
        endfunction
    endclass

endpackage

// ----- tb/tb.sv -----
// Top-level testbench for adv_chunk_reassembler_core: drives report bytes, buffer
// reads and handled-id loads, checks every result against the scoreboard.
// Depends on acr_pkg, acr_stream_if, acr_sb_pkg and the core.
`timescale 1ns / 1ps
module tb;
    import acr_pkg::*;
    import acr_sb_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int PHASE_ITEMS    = 120;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic [7:0] t_byte_q [$];

    typedef enum int {
        FLAW_NONE,
        FLAW_COMPANY,
        FLAW_TAG_I,
        FLAW_TAG_V,
        FLAW_TYPE_Q,
        FLAW_COUNT_ZERO,
        FLAW_COUNT_HIGH,
        FLAW_INDEX,
        FLAW_PLEN,
        FLAW_LEN_ZERO,
        FLAW_LEN_LONG,
        FLAW_NOT_MFG
    } t_chunk_flaw;

    logic clk = 1'b0;
    logic rst_n;

    acr_stream_if #(.T(t_req)) req_if ();
    acr_stream_if #(.T(t_rsp)) rsp_if ();
    acr_stream_if #(.T(t_cfg)) cfg_if ();

    adv_chunk_reassembler_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    reassembly_scoreboard sb;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    int   sent_count = 0;
    t_cfg company_now = COMPANY_ID_RESET;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side backpressure
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && req_if.valid && req_if.ready) sb.note_request(req_if.data);
        if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
        if (cfg_if.valid && cfg_if.ready) sb.set_company(cfg_if.data);
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_req random_request();
        t_req q;
        q.func            = FUNC_REPORT;
        q.data_byte       = 8'($urandom);
        q.first_of_report = 1'b0;
        q.report_len      = 8'($urandom);
        q.read_addr       = 9'($urandom);
        q.handled_id      = 16'($urandom);
        return q;
    endfunction

    task automatic send_request(input t_req q);
        while ($urandom_range(0, 99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= q;
        do @(posedge clk); while (!req_if.ready);
        sent_count++;
    endtask

    task automatic send_report(input t_byte_q bytes, input int rlen);
        t_req q;
        foreach (bytes[i]) begin
            q = random_request();
            q.data_byte       = bytes[i];
            q.first_of_report = (i == 0);
            q.report_len      = 8'(rlen);
            send_request(q);
        end
    endtask

    // one report carrying one manufacturer-data chunk, optionally damaged
    task automatic send_chunk(input logic [15:0] id, input int count_f, input int index_f,
                              input int plen, input t_chunk_flaw flaw);
        t_byte_q bytes;
        int s, extra, n, rlen;
        logic [7:0] lo, hi, ti, tv, tq, mt, cnt_b, idx_b, plen_f;
        bytes = {};
        if ($urandom_range(0, 3) == 0) begin
            // short leading structure of any type, always skipped
            n = $urandom_range(1, 4);
            bytes.push_back(8'(n));
            repeat (n) bytes.push_back(8'($urandom));
        end
        s      = bytes.size();
        extra  = $urandom_range(0, 2);
        lo     = company_now[7:0];
        hi     = company_now[15:8];
        ti     = TAG_I;
        tv     = TAG_V;
        tq     = TYPE_Q;
        mt     = AD_TYPE_MFG;
        cnt_b  = 8'(count_f);
        idx_b  = 8'(index_f);
        plen_f = 8'(plen);
        case (flaw)
            FLAW_COMPANY: begin
                if ($urandom_range(0, 1)) lo ^= 8'($urandom_range(1, 255));
                else hi ^= 8'($urandom_range(1, 255));
            end
            FLAW_TAG_I:      ti ^= 8'($urandom_range(1, 255));
            FLAW_TAG_V:      tv ^= 8'($urandom_range(1, 255));
            FLAW_TYPE_Q:     tq ^= 8'($urandom_range(1, 255));
            FLAW_COUNT_ZERO: cnt_b = 8'd0;
            FLAW_COUNT_HIGH: cnt_b = 8'($urandom_range(MAX_CHUNKS_DEF + 1, 255));
            FLAW_INDEX:      idx_b = 8'($urandom_range(count_f, 255));
            FLAW_PLEN:       plen_f = 8'(plen + extra + 1 + $urandom_range(0, 3));
            FLAW_NOT_MFG:    mt = 8'($urandom_range(0, 254));
            default: ;
        endcase
        bytes.push_back(8'(11 + plen + extra));
        bytes.push_back(mt);
        bytes.push_back(lo);
        bytes.push_back(hi);
        bytes.push_back(ti);
        bytes.push_back(tv);
        bytes.push_back(tq);
        bytes.push_back(id[7:0]);
        bytes.push_back(id[15:8]);
        bytes.push_back(cnt_b);
        bytes.push_back(idx_b);
        bytes.push_back(plen_f);
        repeat (plen + extra) bytes.push_back(8'($urandom));
        if ($urandom_range(0, 3) == 0) begin
            bytes.push_back(8'd1);
            bytes.push_back(8'($urandom));
        end
        rlen = bytes.size();
        if (flaw == FLAW_LEN_ZERO) bytes[s] = 8'd0;
        if (flaw == FLAW_LEN_LONG) bytes[s] = 8'(rlen - s);
        // bytes past the end of the report
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom));
        send_report(bytes, rlen);
    endtask

    task automatic send_noise();
        t_req q;
        int k;
        q = random_request();
        k = $urandom_range(0, 99);
        if (k < 45 && sb.written_addrs.size() > 0) begin
            q.func      = FUNC_READ;
            q.read_addr = 9'(sb.written_addrs[$urandom_range(0, sb.written_addrs.size() - 1)]);
        end else if (k < 65) begin
            q.func = FUNC_SET_ID;
            case ($urandom_range(0, 3))
                0: q.handled_id = 16'h0000;
                1: q.handled_id = 16'hFFFF;
                default: ;
            endcase
        end else if (k < 75) begin
            q.func = FUNC_UNUSED;
        end else begin
            q.first_of_report = 1'($urandom);
        end
        send_request(q);
    endtask

    task automatic send_message();
        logic [15:0] id;
        int count, j, tmp, plen;
        int order [$];
        id = 16'($urandom);
        if ($urandom_range(0, 19) == 0) id = sb.handled;
        count = $urandom_range(1, MAX_CHUNKS_DEF);
        order = {};
        for (int i = 0; i < count; i++) order.push_back(i);
        for (int i = count - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_chunk(id, count, order[i], $urandom_range(0, 12),
                           t_chunk_flaw'($urandom_range(FLAW_COMPANY, FLAW_NOT_MFG)));
            // mostly short payloads; some large ones overlap the next chunk or overrun the buffer
            if ($urandom_range(0, 7) == 0)
                plen = (order[i] == 2) ? $urandom_range(13, 160) : $urandom_range(13, 230);
            else
                plen = $urandom_range(0, 12);
            send_chunk(id, count, order[i], plen, FLAW_NONE);
            if ($urandom_range(0, 11) == 0)
                send_chunk(id, count, order[i], $urandom_range(0, 12), FLAW_NONE);
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_noise();
            if ($urandom_range(0, 24) == 0) break;
        end
        repeat ($urandom_range(0, 4)) send_noise();
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (sb.expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_company(input t_cfg v);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        company_now = v;
    endtask

    initial begin
        t_byte_q pattern;
        t_req    q;
        t_cfg    cfg_val;
        int      phase_end;
        bit      paused;
        sb = new();
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        paused = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unused func, id load, report corner cases, one empty chunk
        q = random_request();
        q.func = FUNC_UNUSED;
        send_request(q);
        q = random_request();
        q.func = FUNC_SET_ID;
        q.handled_id = 16'h0000;
        send_request(q);
        pattern = {8'hFF};
        send_report(pattern, 0);
        pattern = {8'h00, 8'h07};
        send_report(pattern, 2);
        pattern = {8'h05, 8'hAA};
        send_report(pattern, 1);
        pattern = {8'h02, 8'h01, 8'h06, 8'h04, AD_TYPE_MFG, 8'h01, 8'h02, 8'h03};
        send_report(pattern, 8);
        send_chunk(16'h1234, 1, 0, 0, FLAW_NONE);

        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                wait_drained();
                case (ph)
                    1: cfg_val = 16'h0000;
                    3: cfg_val = 16'hFFFF;
                    default: cfg_val = 16'($urandom);
                endcase
                write_company(cfg_val);
            end
            case (ph)
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                3: begin idle_pct = 12; stall_pct = 12; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            phase_end = sent_count + PHASE_ITEMS;
            while (sent_count < phase_end) begin
                send_message();
                if (ph == 4 && !paused && sent_count >= phase_end - PHASE_ITEMS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d requests: %0d buffer reads, %0d completed messages, %0d errors,",
                 sb.n_requests, sb.n_reads, sb.n_done, sb.n_errors);
        $display("across five company-id settings and mixed sender/receiver idling.");
        if (sb.n_errors == 0 && sb.expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
src/acr_pkg.sv
src/acr_stream_if.sv
src/adv_chunk_reassembler_core.sv
src/acr_checker.sv
tb/acr_sb_pkg.sv
tb/tb.sv
